@@ rtl/core/sacf_pkg.sv @@
// Shared types and constants for the set-associative FIFO-replacement tag store.
`default_nettype none
package sacf_pkg;

	localparam int OFFSET_W = 5;
	localparam int INDEX_W  = 3;
	localparam int WAYSEL_W = 3;
	localparam int CFG_W    = 5;

	typedef enum logic [1:0] {
		CFG_OFFSET_BITS = 2'd0,
		CFG_INDEX_BITS  = 2'd1,
		CFG_WAYS_IN_USE = 2'd2
	} cfg_reg_t;

	localparam logic [OFFSET_W-1:0] OFFSET_RST = 5'd3;
	localparam logic [INDEX_W-1:0]  INDEX_RST  = 3'd6;
	localparam logic [WAYSEL_W-1:0] WAYS_RST   = 3'd1;

endpackage
`default_nettype wire

@@ rtl/core/set_assoc_cache_fifo_lookup.sv @@
// Top level: tag store of a set-associative cache with FIFO replacement.
// The tag/age row is read into the lookup stage; then the set update and result are registered.
// One transaction per cycle unless stalled; same-set back-to-back updates are forwarded.
// The result register decouples the sides: input stalls only when it is full and stalled.
// Reset clears config to defaults, all line valid bits and both counters at once;
// ages and tags of invalid lines read as zero/ignored, so no clearing pass is needed.
`default_nettype none
module set_assoc_cache_fifo_lookup #(
	parameter int WAYS      = 4,
	parameter int SETS      = 64,
	parameter int ADDR_BITS = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [1:0]                    cfg_index,
	input  wire logic [sacf_pkg::CFG_W-1:0]    cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [ADDR_BITS-1:0]          address,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               hit,
	output logic [1:0]                         way,
	output logic [31:0]                        hit_total,
	output logic [31:0]                        access_total
);

	localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int AGE_W   = $clog2(WAYS + 1);
	localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int IDX_MAX = $clog2(SETS + 1) - 1;

	typedef logic [WAYS-1:0][ADDR_BITS-1:0] tag_row_t;
	typedef logic [WAYS-1:0][AGE_W-1:0]     age_row_t;

	logic [sacf_pkg::OFFSET_W-1:0] offset_bits_q;
	logic [sacf_pkg::INDEX_W-1:0]  index_bits_q;
	logic [sacf_pkg::WAYSEL_W-1:0] ways_in_use_q;

	tag_row_t tag_mem [SETS];
	age_row_t age_mem [SETS];
	logic [SETS-1:0][WAYS-1:0] valid_q;

	logic                 advance, accept, fire_s1, wr_s1;
	logic [3:0]           k_eff;
	logic [63:0]          addr_ext, shifted, set_full, tag_full;
	logic [SET_W-1:0]     set_in;
	logic [ADDR_BITS-1:0] tag_in;

	logic                 valid_s1, byp_s1;
	logic [SET_W-1:0]     set_s1;
	logic [ADDR_BITS-1:0] tag_s1;
	tag_row_t             rd_tag_s1, byp_tag_s1, cur_tag, new_tag;
	age_row_t             rd_age_s1, byp_age_s1, cur_age, new_age;

	logic [AGE_W-1:0]     n_eff;
	logic [WAYS-1:0]      vrow;
	logic                 hit_any, fill_found;
	logic [WAY_W-1:0]     hit_way, fill_way, res_way;
	logic [AGE_W-1:0]     age_eff;

	logic [31:0]          hits_q, acc_q, hits_nx, acc_nx;
	logic                 out_valid_q, hit_q;
	logic [1:0]           way_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_bits_q <= sacf_pkg::OFFSET_RST;
			index_bits_q  <= sacf_pkg::INDEX_RST;
			ways_in_use_q <= sacf_pkg::WAYS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sacf_pkg::CFG_OFFSET_BITS: offset_bits_q <= cfg_data;
				sacf_pkg::CFG_INDEX_BITS:  index_bits_q  <= cfg_data[sacf_pkg::INDEX_W-1:0];
				sacf_pkg::CFG_WAYS_IN_USE: ways_in_use_q <= cfg_data[sacf_pkg::WAYSEL_W-1:0];
				default: ;
			endcase
		end
	end

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = !advance;
	assign accept   = in_valid && advance;
	assign fire_s1  = valid_s1 && advance;
	assign wr_s1    = fire_s1 && !hit_any;

	// set index and tag of the incoming address
	always_comb begin
		if (32'(index_bits_q) > IDX_MAX)
			k_eff = 4'(IDX_MAX);
		else
			k_eff = 4'(index_bits_q);
		addr_ext = 64'(address);
		shifted  = addr_ext >> offset_bits_q;
		set_full = shifted & ((64'd1 << k_eff) - 64'd1);
		tag_full = addr_ext >> (6'(offset_bits_q) + 6'(k_eff));
		set_in   = set_full[SET_W-1:0];
		tag_in   = tag_full[ADDR_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_tag_s1 <= tag_mem[set_in];
			rd_age_s1 <= age_mem[set_in];
		end
		if (wr_s1) begin
			tag_mem[set_s1] <= new_tag;
			age_mem[set_s1] <= new_age;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			set_s1     <= set_in;
			tag_s1     <= tag_in;
			byp_tag_s1 <= new_tag;
			byp_age_s1 <= new_age;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			byp_s1   <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
			byp_s1   <= in_valid && wr_s1 && (set_s1 == set_in);
		end
	end

	// lookup and FIFO update of one set
	always_comb begin
		if (ways_in_use_q == '0)
			n_eff = AGE_W'(1);
		else if (32'(ways_in_use_q) > WAYS)
			n_eff = AGE_W'(WAYS);
		else
			n_eff = AGE_W'(ways_in_use_q);

		cur_tag    = byp_s1 ? byp_tag_s1 : rd_tag_s1;
		cur_age    = byp_s1 ? byp_age_s1 : rd_age_s1;
		vrow       = valid_q[set_s1];
		hit_any    = 1'b0;
		hit_way    = '0;
		fill_found = 1'b0;
		fill_way   = '0;
		new_tag    = cur_tag;
		new_age    = cur_age;
		age_eff    = '0;

		for (int i = 0; i < WAYS; i++) begin
			if (i < int'(n_eff) && !hit_any && vrow[i] && cur_tag[i] == tag_s1) begin
				hit_any = 1'b1;
				hit_way = WAY_W'(i);
			end
		end

		for (int i = 0; i < WAYS; i++) begin
			age_eff = vrow[i] ? cur_age[i] : '0;
			new_age[i] = age_eff;
			if (i < int'(n_eff)) begin
				if (!fill_found && age_eff == '0) begin
					fill_found = 1'b1;
					fill_way   = WAY_W'(i);
					new_tag[i] = tag_s1;
					new_age[i] = n_eff - AGE_W'(1);
				end else if (age_eff != '0) begin
					new_age[i] = age_eff - AGE_W'(1);
				end
			end
		end

		if (hit_any)
			res_way = hit_way;
		else if (fill_found)
			res_way = fill_way;
		else
			res_way = '0;

		hits_nx = (hit_any && hits_q != '1) ? hits_q + 32'd1 : hits_q;
		acc_nx  = (acc_q != '1) ? acc_q + 32'd1 : acc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			hits_q      <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance)
				out_valid_q <= valid_s1;
			if (fire_s1) begin
				hits_q <= hits_nx;
				acc_q  <= acc_nx;
			end
			if (wr_s1 && fill_found)
				valid_q[set_s1][fill_way] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			hit_q <= hit_any;
			way_q <= 2'(res_way);
		end
	end

	assign out_valid    = out_valid_q;
	assign hit          = hit_q;
	assign way          = way_q;
	assign hit_total    = hits_q;
	assign access_total = acc_q;

	// forwarding is only armed for an item held in the lookup stage
	a_byp_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		byp_s1 |-> valid_s1)
		else $error("bypass flag without item in lookup stage");

	a_hits_le_access: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> hit_total <= access_total)
		else $error("hit count exceeds access count");

	a_access_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && access_total != '1 |=>
		!out_valid || access_total == $past(access_total) + 32'd1)
		else $error("access count skipped or repeated a transaction");

	a_hit_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && hit_total != '1 |=>
		!out_valid || hit_total == $past(hit_total) + 32'(hit))
		else $error("hit count does not follow hit flag");

endmodule
`default_nettype wire

@@ tb/sv/tb_set_assoc_cache_fifo_lookup.sv @@
// Testbench for the set-associative FIFO-replacement tag store: directed and random lookups.
`timescale 1ns / 100ps

typedef struct packed {
	logic        hit;
	logic [1:0]  way;
	logic [31:0] hit_total;
	logic [31:0] access_total;
} lookup_t;

class tag_store_tracker;
	localparam int NWAYS = 4;
	localparam int NSETS = 64;
	localparam int MAX_K = $clog2(NSETS);
	localparam int LINES = NSETS * NWAYS;

	bit          line_ok[LINES];
	logic [63:0] line_key[LINES];
	int          line_fifo[LINES];
	logic [31:0] hits;
	logic [31:0] accesses;
	int          offset_cfg;
	int          index_cfg;
	int          ways_cfg;
	lookup_t     expected_lookups[$];
	int          errors;

	function new();
		offset_cfg = 3;
		index_cfg  = 6;
		ways_cfg   = 1;
		hits       = '0;
		accesses   = '0;
		errors     = 0;
	endfunction

	function void set_config(int o, int k, int n);
		offset_cfg = o & 31;
		index_cfg  = k & 7;
		ways_cfg   = n & 7;
	endfunction

	function void predict_lookup(logic [31:0] addr);
		int          k;
		int          n;
		int          base;
		int          p;
		int          hit_way;
		bit          found;
		bit          filled;
		logic [63:0] a;
		logic [63:0] set_i;
		logic [63:0] key;
		lookup_t     r;
		k = (index_cfg < MAX_K) ? index_cfg : MAX_K;
		n = (ways_cfg == 0) ? 1 : ((ways_cfg > NWAYS) ? NWAYS : ways_cfg);
		a = {32'b0, addr};
		set_i = (a >> offset_cfg) & ((64'd1 << k) - 64'd1);
		key = a >> (offset_cfg + k);
		base = int'(set_i) * NWAYS;
		found = 1'b0;
		hit_way = 0;
		for (int i = 0; i < n; i++) begin
			if (!found && line_ok[base + i] && line_key[base + i] == key) begin
				found = 1'b1;
				hit_way = i;
			end
		end
		if (!found) begin
			filled = 1'b0;
			for (int i = 0; i < n; i++) begin
				p = base + i;
				if (!filled && line_fifo[p] == 0) begin
					line_key[p]  = key;
					line_ok[p]   = 1'b1;
					line_fifo[p] = n;
					hit_way = i;
					filled = 1'b1;
				end
				if (line_fifo[p] != 0)
					line_fifo[p]--;
			end
		end else if (hits != '1) begin
			hits++;
		end
		if (accesses != '1)
			accesses++;
		r.hit          = found;
		r.way          = hit_way[1:0];
		r.hit_total    = hits;
		r.access_total = accesses;
		expected_lookups.push_back(r);
	endfunction

	task flag_mismatch(string msg);
		errors++;
		$display("mismatch: %s", msg);
	endtask

	task check_lookup(lookup_t got);
		lookup_t want;
		if (expected_lookups.size() == 0) begin
			flag_mismatch("result transaction with no access pending");
			return;
		end
		want = expected_lookups.pop_front();
		if (got.hit !== want.hit)
			flag_mismatch($sformatf("hit got %0b want %0b", got.hit, want.hit));
		if (got.way !== want.way)
			flag_mismatch($sformatf("way got %0d want %0d", got.way, want.way));
		if (got.hit_total !== want.hit_total)
			flag_mismatch($sformatf("hit_total got %0d want %0d",
				got.hit_total, want.hit_total));
		if (got.access_total !== want.access_total)
			flag_mismatch($sformatf("access_total got %0d want %0d",
				got.access_total, want.access_total));
	endtask
endclass

module tb_set_assoc_cache_fifo_lookup;

	localparam int DRAIN      = 8;
	localparam int PER_PHASE  = 110;
	localparam int NUM_PHASES = 12;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [1:0]                 cfg_index;
	logic [sacf_pkg::CFG_W-1:0] cfg_data;
	logic                       in_valid;
	logic                       in_stall;
	logic [31:0]                address;
	logic                       out_valid;
	logic                       out_stall;
	logic                       hit;
	logic [1:0]                 way;
	logic [31:0]                hit_total;
	logic [31:0]                access_total;

	tag_store_tracker sb = new();
	int               calm[2];
	logic [31:0]      recent[$];
	logic [31:0]      tag_pool[6];
	logic [31:0]      set_pool[3];

	set_assoc_cache_fifo_lookup uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.address      (address),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.hit          (hit),
		.way          (way),
		.hit_total    (hit_total),
		.access_total (access_total)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// side 0 is the sender, side 1 the receiver
	function automatic int draw_wait(int side);
		if (calm[side] > 0) begin
			calm[side]--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm[side] = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 9);
	endfunction

	task automatic send_access(input logic [31:0] a);
		int w;
		w = draw_wait(0);
		@(negedge clk);
		if (w > 0) begin
			in_valid = 1'b0;
			repeat (w) @(negedge clk);
		end
		address  = a;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		sb.predict_lookup(a);
		recent.push_back(a);
		if (recent.size() > 16)
			void'(recent.pop_front());
	endtask

	task automatic go_idle();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.expected_lookups.size() != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);
	endtask

	task automatic apply_config(input int o, input int k, input int n);
		go_idle();
		cfg_we    = 1'b1;
		cfg_index = sacf_pkg::CFG_OFFSET_BITS;
		cfg_data  = o[sacf_pkg::CFG_W-1:0];
		@(negedge clk);
		cfg_index = sacf_pkg::CFG_INDEX_BITS;
		cfg_data  = k[sacf_pkg::CFG_W-1:0];
		@(negedge clk);
		cfg_index = sacf_pkg::CFG_WAYS_IN_USE;
		cfg_data  = n[sacf_pkg::CFG_W-1:0];
		@(negedge clk);
		cfg_we = 1'b0;
		sb.set_config(o, k, n);
	endtask

	function automatic logic [31:0] pick_address(int o, int k);
		logic [63:0] a;
		int          r;
		int          kk;
		r  = $urandom_range(0, 99);
		kk = (k < 6) ? k : 6;
		if (r < 12 || recent.size() == 0)
			return $urandom;
		if (r < 30)
			return recent[$urandom_range(0, recent.size() - 1)];
		a = (64'(tag_pool[$urandom_range(0, 5)]) << (o + kk))
			| ((64'(set_pool[$urandom_range(0, 2)]) & ((64'd1 << kk) - 64'd1)) << o)
			| (64'($urandom) & ((64'd1 << o) - 64'd1));
		return a[31:0];
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_lookup({hit, way, hit_total, access_total});
	end

	initial begin
		int hold;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			hold = draw_wait(1);
			if (hold > 0) begin
				out_stall = 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall = 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int offs[NUM_PHASES];
		int idxs[NUM_PHASES];
		int wys[NUM_PHASES];
		offs      = '{0, 16, 31, 4, 2, 5, 0, 1, 6, 12, 0, 0};
		idxs      = '{0, 6, 7, 2, 3, 1, 6, 2, 4, 0, 0, 0};
		wys       = '{1, 4, 4, 4, 2, 3, 0, 7, 5, 4, 0, 0};
		cfg_we    = 1'b0;
		cfg_index = sacf_pkg::CFG_OFFSET_BITS;
		cfg_data  = '0;
		in_valid  = 1'b0;
		address   = '0;
		calm[0]   = 0;
		calm[1]   = 0;
		arst_n    = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset config: 8-byte blocks, 64 sets, direct mapped
		send_access(32'h0000_0000);
		send_access(32'h0000_0000);
		send_access(32'h0000_0007);
		send_access(32'hFFFF_FFFF);
		send_access(32'hFFFF_FFFF);
		send_access(32'h0000_0200);
		send_access(32'h0000_0000);
		apply_config(3, 6, 4);
		send_access(32'h0000_0400);
		send_access(32'h0000_0600);
		send_access(32'h0000_0800);
		send_access(32'h0000_0800);
		send_access(32'h0000_0400);
		// fewer ways: way 0 still aged, miss fills nothing
		apply_config(3, 6, 1);
		send_access(32'h0000_0A00);
		send_access(32'h0000_0400);
		send_access(32'h0000_0800);
		apply_config(3, 6, 0);
		send_access(32'h0000_0800);
		apply_config(3, 6, 7);
		send_access(32'h0000_0600);
		apply_config(3, 7, 4);
		send_access(32'hFFFF_FFF8);
		apply_config(31, 6, 4);
		send_access(32'h8000_0000);
		send_access(32'h0000_0000);
		apply_config(0, 0, 2);
		send_access(32'h1234_5678);
		send_access(32'h1234_5678);
		send_access(32'hEDCB_A987);

		offs[10] = $urandom_range(0, 31);
		idxs[10] = $urandom_range(0, 7);
		wys[10]  = $urandom_range(0, 7);
		offs[11] = $urandom_range(0, 16);
		idxs[11] = $urandom_range(0, 7);
		wys[11]  = $urandom_range(1, 4);
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			apply_config(offs[ph], idxs[ph], wys[ph]);
			foreach (tag_pool[i])
				tag_pool[i] = $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom;
			foreach (set_pool[i])
				set_pool[i] = $urandom_range(0, 63);
			for (int n = 0; n < PER_PHASE; n++)
				send_access(pick_address(offs[ph], idxs[ph]));
		end

		go_idle();
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
